// ===== rtl/adcomp_pkg.sv =====
// Package for the antialiased disc pixel compositor.
// Holds widths, register indexes and shared types; no dependencies.
`default_nettype none

package adcomp_pkg;

  localparam int COORD_BITS = 12;
  localparam int AA_WIDTH   = 2;
  localparam int FRAC_BITS  = 16;

  localparam int CTR_W  = 16;
  localparam int RAD_W  = 12;
  localparam int SCL_W  = 7;
  localparam int CH_W   = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  localparam int CX_W     = CTR_W + SCL_W;
  localparam int RQ_W     = RAD_W + SCL_W;
  localparam int POS_W    = COORD_BITS + 4;
  localparam int SQ_W     = 2 * CX_W;
  localparam int DD_W     = SQ_W + 1;
  localparam int DD_PAIRS = (DD_W + 1) / 2;
  localparam int DDP_W    = 2 * DD_PAIRS;
  localparam int EXTRA    = FRAC_BITS - 4;
  localparam int ROOT_W   = DD_PAIRS + EXTRA;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQ_STAGES = (ROOT_W + 1) / 2;
  localparam int COV_W    = FRAC_BITS + 1;
  localparam int WGT_W    = 2 * CH_W;
  localparam int NUM_W    = 3 * CH_W;
  localparam int DIV_STAGES = CH_W / 2;

  localparam logic [ROOT_W-1:0] BAND_Q = ROOT_W'(AA_WIDTH * (2 ** FRAC_BITS));

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIUS,
    REG_SCALE,
    REG_COLOR_R,
    REG_COLOR_G,
    REG_COLOR_B,
    REG_COLOR_A
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_FILL,
    KIND_BLEND
  } kind_e;

  // Channel order: 0 red, 1 green, 2 blue, 3 alpha.
  typedef logic [3:0][CH_W-1:0] rgba_t;

  typedef struct packed {
    logic [CTR_W-1:0] center_x;
    logic [CTR_W-1:0] center_y;
    logic [RAD_W-1:0] radius;
    logic [SCL_W-1:0] scale;
    logic [CH_W-1:0]  color_r;
    logic [CH_W-1:0]  color_g;
    logic [CH_W-1:0]  color_b;
    logic [CH_W-1:0]  color_a;
  } cfg_t;

  typedef struct packed {
    logic            op;
    logic            fill;
    logic [RQ_W-1:0] rq;
    rgba_t           pix;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/adcomp_if.sv =====
// Valid/ready channel interfaces for pixel words in and out.
// Depends on adcomp_pkg.
`default_nettype none

interface adcomp_in_if;
  import adcomp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [CH_W-1:0]       pixel_r;
  logic [CH_W-1:0]       pixel_g;
  logic [CH_W-1:0]       pixel_b;
  logic [CH_W-1:0]       pixel_a;
  modport source (output valid, operation, pixel_x, pixel_y, pixel_r, pixel_g, pixel_b,
                  pixel_a, input ready);
  modport sink (input valid, operation, pixel_x, pixel_y, pixel_r, pixel_g, pixel_b,
                pixel_a, output ready);
endinterface

interface adcomp_out_if;
  import adcomp_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_r;
  logic [CH_W-1:0] out_g;
  logic [CH_W-1:0] out_b;
  logic [CH_W-1:0] out_a;
  logic            changed;
  modport source (output valid, out_r, out_g, out_b, out_a, changed, input ready);
  modport sink (input valid, out_r, out_g, out_b, out_a, changed, output ready);
endinterface

`default_nettype wire

// ===== rtl/adcomp_regs.sv =====
// APB-style configuration registers of the disc compositor.
// Depends on adcomp_pkg.
`default_nettype none

module adcomp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adcomp_pkg::ADDR_W-1:0] paddr,
  input  logic [adcomp_pkg::DATA_W-1:0] pwdata,
  output logic [adcomp_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output adcomp_pkg::cfg_t             cfg_o
);
  import adcomp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= '0;
      cfg_q.center_y <= '0;
      cfg_q.radius   <= '0;
      cfg_q.scale    <= SCL_W'(1);
      cfg_q.color_r  <= '1;
      cfg_q.color_g  <= '0;
      cfg_q.color_b  <= '0;
      cfg_q.color_a  <= '1;
    end else if (wr_en) begin
      unique case (idx)
        REG_CENTER_X: cfg_q.center_x <= pwdata[CTR_W-1:0];
        REG_CENTER_Y: cfg_q.center_y <= pwdata[CTR_W-1:0];
        REG_RADIUS:   cfg_q.radius   <= pwdata[RAD_W-1:0];
        REG_SCALE:    cfg_q.scale    <= pwdata[SCL_W-1:0];
        REG_COLOR_R:  cfg_q.color_r  <= pwdata[CH_W-1:0];
        REG_COLOR_G:  cfg_q.color_g  <= pwdata[CH_W-1:0];
        REG_COLOR_B:  cfg_q.color_b  <= pwdata[CH_W-1:0];
        REG_COLOR_A:  cfg_q.color_a  <= pwdata[CH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_X: prdata = DATA_W'(cfg_q.center_x);
      REG_CENTER_Y: prdata = DATA_W'(cfg_q.center_y);
      REG_RADIUS:   prdata = DATA_W'(cfg_q.radius);
      REG_SCALE:    prdata = DATA_W'(cfg_q.scale);
      REG_COLOR_R:  prdata = DATA_W'(cfg_q.color_r);
      REG_COLOR_G:  prdata = DATA_W'(cfg_q.color_g);
      REG_COLOR_B:  prdata = DATA_W'(cfg_q.color_b);
      REG_COLOR_A:  prdata = DATA_W'(cfg_q.color_a);
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/adcomp_isqrt.sv =====
// Pipelined digit-by-digit square root, two result bits per stage,
// carrying a sideband word alongside. Depends on adcomp_pkg.
`default_nettype none

module adcomp_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [adcomp_pkg::DD_W-1:0]   dd_i,
  input  adcomp_pkg::side_t            side_i,
  output logic                         valid_o,
  output logic [adcomp_pkg::ROOT_W-1:0] root_o,
  output adcomp_pkg::side_t            side_o
);
  import adcomp_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  function automatic sq_t sq_step(sq_t cur, logic [1:0] pair);
    logic [REM_W+1:0] r;
    logic [REM_W+1:0] t;
    sq_t              nx;
    r = {cur.rem, pair};
    t = (REM_W + 2)'({cur.root, 2'b01});
    if (r >= t) begin
      nx.rem  = REM_W'(r - t);
      nx.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nx.rem  = REM_W'(r);
      nx.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nx;
  endfunction

  logic  vld_q  [SQ_STAGES];
  sq_t   sq_q   [SQ_STAGES];
  logic [DDP_W-1:0] n_q [SQ_STAGES];
  side_t side_q [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    localparam int J0 = 2 * g;
    localparam int J1 = 2 * g + 1;

    logic                  vld_in;
    sq_t                   sq_in;
    sq_t                   sq_mid;
    sq_t                   sq_d;
    logic [DDP_W-1:0]      n_in;
    logic [2*ROOT_W-1:0]   np;
    side_t                 side_in;

    if (g == 0) begin : g_first
      assign vld_in  = valid_i;
      assign sq_in   = '0;
      assign n_in    = DDP_W'(dd_i);
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign sq_in   = sq_q[g-1];
      assign n_in    = n_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Past the radicand the digits are zero pairs, giving the fraction bits.
    assign np     = {n_in, {(2 * EXTRA){1'b0}}};
    assign sq_mid = sq_step(sq_in, np[2*ROOT_W-1-2*J0 -: 2]);

    if (J1 < ROOT_W) begin : g_two
      assign sq_d = sq_step(sq_mid, np[2*ROOT_W-1-2*J1 -: 2]);
    end else begin : g_one
      assign sq_d = sq_mid;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[g]   <= sq_d;
        n_q[g]    <= n_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[SQ_STAGES-1];
  assign root_o  = sq_q[SQ_STAGES-1].root;
  assign side_o  = side_q[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/antialiased_disc_pixel_compositor.sv =====
// Top level of the antialiased disc pixel compositor.
// Depends on adcomp_pkg, adcomp_if, adcomp_regs and adcomp_isqrt.
//
// Channel   Role       Protocol           Word
// pix_in    sink       valid/ready        operation, pixel_x/y, pixel_rgba
// pix_out   source     valid/ready        out_rgba, changed
// apb       slave      psel/penable       8 config registers at 4*i
//
// One word enters per cycle while pix_out does not stall; it passes 4 geometry stages,
// 18 square root stages (two root bits each), 4 coverage/weight stages,
// 4 divider stages (two quotient bits each) and the output register.
// Reset clears all valid bits and loads the register defaults.
// A stall at pix_out freezes the whole pipeline; pix_in ready drops with it.
`default_nettype none

module antialiased_disc_pixel_compositor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  adcomp_in_if.sink                     pix_in,
  adcomp_out_if.source                  pix_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adcomp_pkg::ADDR_W-1:0] paddr,
  input  logic [adcomp_pkg::DATA_W-1:0] pwdata,
  output logic [adcomp_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import adcomp_pkg::*;

  localparam int BL_LAST = 3 + DIV_STAGES;

  typedef struct packed {
    logic             op;
    rgba_t            pix;
    logic [POS_W-1:0] x16;
    logic [POS_W-1:0] y16;
    logic [CX_W-1:0]  cx;
    logic [CX_W-1:0]  cy;
    logic [RQ_W-1:0]  rq;
  } g1_t;

  typedef struct packed {
    logic            op;
    rgba_t           pix;
    logic [CX_W-1:0] dx;
    logic [CX_W-1:0] dy;
    logic [RQ_W-1:0] rq;
  } g2_t;

  typedef struct packed {
    logic              op;
    rgba_t             pix;
    logic [SQ_W-1:0]   sqx;
    logic [SQ_W-1:0]   sqy;
    logic [2*RQ_W-1:0] rq2;
    logic [RQ_W-1:0]   rq;
  } g3_t;

  typedef struct packed {
    logic [DD_W-1:0] dd;
    side_t           side;
  } g4_t;

  typedef struct packed {
    side_t            side;
    logic             inband;
    logic [COV_W-1:0] cov;
  } cv_t;

  typedef struct packed {
    kind_e                 kind;
    logic [CH_W-1:0]       fa;
    logic [2:0][CH_W-1:0]  fg;
    rgba_t                 bg;
    logic [WGT_W-1:0]      wf;
    logic [WGT_W-1:0]      wb;
    logic [WGT_W-1:0]      s;
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][CH_W-1:0]  q;
  } bl_t;

  cfg_t cfg;

  adcomp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic en;
  logic out_vld_q;

  assign en           = !out_vld_q || pix_out.ready;
  assign pix_in.ready = en;

  // Geometry stages.
  logic gv_q [4];
  g1_t  g1_d, g1_q;
  g2_t  g2_d, g2_q;
  g3_t  g3_d, g3_q;
  g4_t  g4_d, g4_q;

  always_comb begin
    g1_d.op  = pix_in.operation;
    g1_d.pix = {pix_in.pixel_a, pix_in.pixel_b, pix_in.pixel_g, pix_in.pixel_r};
    g1_d.x16 = {pix_in.pixel_x, 4'b0000};
    g1_d.y16 = {pix_in.pixel_y, 4'b0000};
    g1_d.cx  = CX_W'(cfg.center_x) * CX_W'(cfg.scale);
    g1_d.cy  = CX_W'(cfg.center_y) * CX_W'(cfg.scale);
    g1_d.rq  = RQ_W'(cfg.radius) * RQ_W'(cfg.scale);
  end

  always_comb begin
    g2_d.op  = g1_q.op;
    g2_d.pix = g1_q.pix;
    g2_d.rq  = g1_q.rq;
    g2_d.dx  = (g1_q.cx >= CX_W'(g1_q.x16)) ? g1_q.cx - CX_W'(g1_q.x16)
                                            : CX_W'(g1_q.x16) - g1_q.cx;
    g2_d.dy  = (g1_q.cy >= CX_W'(g1_q.y16)) ? g1_q.cy - CX_W'(g1_q.y16)
                                            : CX_W'(g1_q.y16) - g1_q.cy;
  end

  always_comb begin
    g3_d.op  = g2_q.op;
    g3_d.pix = g2_q.pix;
    g3_d.rq  = g2_q.rq;
    g3_d.sqx = SQ_W'(g2_q.dx) * SQ_W'(g2_q.dx);
    g3_d.sqy = SQ_W'(g2_q.dy) * SQ_W'(g2_q.dy);
    g3_d.rq2 = (2 * RQ_W)'(g2_q.rq) * (2 * RQ_W)'(g2_q.rq);
  end

  always_comb begin
    g4_d.dd        = DD_W'(g3_q.sqx) + DD_W'(g3_q.sqy);
    g4_d.side.op   = g3_q.op;
    g4_d.side.pix  = g3_q.pix;
    g4_d.side.rq   = g3_q.rq;
    g4_d.side.fill = g4_d.dd <= DD_W'(g3_q.rq2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) gv_q[i] <= 1'b0;
    end else if (en) begin
      gv_q[0] <= pix_in.valid;
      for (int i = 1; i < 4; i++) gv_q[i] <= gv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q <= g1_d;
      g2_q <= g2_d;
      g3_q <= g3_d;
      g4_q <= g4_d;
    end
  end

  // Distance in pixels with FRAC_BITS fraction bits.
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  adcomp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (gv_q[3]),
    .dd_i    (g4_q.dd),
    .side_i  (g4_q.side),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Coverage stage.
  logic [ROOT_W-1:0] rf;
  logic [ROOT_W-1:0] ex;
  logic [ROOT_W-1:0] diff;
  cv_t               cv_d, cv_q;
  logic              cv_vld_q;

  always_comb begin
    rf          = ROOT_W'({sq_side.rq, {EXTRA{1'b0}}});
    ex          = (sq_root > rf) ? sq_root - rf : '0;
    diff        = BAND_Q - ex;
    cv_d.side   = sq_side;
    cv_d.inband = ex < BAND_Q;
    cv_d.cov    = COV_W'(diff / AA_WIDTH);
  end

  // Source selection: disc over pixel, or pixel over white.
  logic [CH_W+COV_W-1:0] a_prod;
  bl_t                   bl_d  [1:BL_LAST];
  bl_t                   bl_q  [1:BL_LAST];
  logic                  blv_q [1:BL_LAST];

  always_comb begin
    a_prod        = (CH_W + COV_W)'(cfg.color_a) * (CH_W + COV_W)'(cv_q.cov);
    bl_d[1]       = '0;
    bl_d[1].bg    = cv_q.side.pix;
    bl_d[1].fg    = {cfg.color_b, cfg.color_g, cfg.color_r};
    if (cv_q.side.op) begin
      bl_d[1].kind = KIND_BLEND;
      bl_d[1].fa   = cv_q.side.pix[3];
      bl_d[1].fg   = cv_q.side.pix[2:0];
      bl_d[1].bg   = '1;
    end else if (cv_q.side.fill) begin
      bl_d[1].kind = KIND_FILL;
      bl_d[1].fa   = cfg.color_a;
    end else if (cv_q.inband && (cv_q.cov != '0)) begin
      bl_d[1].kind = KIND_BLEND;
      bl_d[1].fa   = a_prod[FRAC_BITS +: CH_W];
    end else begin
      bl_d[1].kind = KIND_PASS;
    end
  end

  // Over-operator weights.
  always_comb begin
    bl_d[2]    = bl_q[1];
    bl_d[2].wf = WGT_W'(bl_q[1].fa) * WGT_W'(8'd255);
    bl_d[2].wb = WGT_W'(bl_q[1].bg[3]) * WGT_W'(8'd255 - bl_q[1].fa);
  end

  always_comb begin
    bl_d[3]   = bl_q[2];
    bl_d[3].s = bl_q[2].wf + bl_q[2].wb;
    bl_d[3].q = '0;
    for (int c = 0; c < 3; c++) begin
      bl_d[3].rem[c] = NUM_W'(bl_q[2].fg[c]) * NUM_W'(bl_q[2].wf)
                     + NUM_W'(bl_q[2].bg[c]) * NUM_W'(bl_q[2].wb);
    end
  end

  // Restoring divide, two quotient bits per stage; quotients stay below 256.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_comb begin
      logic [NUM_W-1:0] cand;
      int               k;
      bl_d[4+g] = bl_q[3+g];
      for (int i = 0; i < 2; i++) begin
        k    = CH_W - 1 - 2 * g - i;
        cand = NUM_W'(bl_q[3+g].s) << k;
        for (int c = 0; c < 3; c++) begin
          if (bl_d[4+g].rem[c] >= cand) begin
            bl_d[4+g].rem[c] = bl_d[4+g].rem[c] - cand;
            bl_d[4+g].q[c][k] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_vld_q <= 1'b0;
      for (int i = 1; i <= BL_LAST; i++) blv_q[i] <= 1'b0;
    end else if (en) begin
      cv_vld_q <= sq_vld;
      blv_q[1] <= cv_vld_q;
      for (int i = 2; i <= BL_LAST; i++) blv_q[i] <= blv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cv_q <= cv_d;
      for (int i = 1; i <= BL_LAST; i++) bl_q[i] <= bl_d[i];
    end
  end

  // Output register.
  bl_t              fin;
  logic [WGT_W:0]   a_div;
  rgba_t            res_d, res_q;
  logic             chg_d, chg_q;

  assign fin = bl_q[BL_LAST];

  always_comb begin
    // Exact floor(s / 255) for 16-bit s.
    a_div = (WGT_W + 1)'(fin.s) + (WGT_W + 1)'(1) + (WGT_W + 1)'(fin.s >> 8);
    res_d = fin.bg;
    chg_d = 1'b1;
    case (fin.kind)
      KIND_FILL: res_d = {fin.fa, fin.fg};
      KIND_BLEND: begin
        if (fin.fa != '0) begin
          res_d = {a_div[8 +: CH_W], fin.q};
        end
      end
      default: chg_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= blv_q[BL_LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      chg_q <= chg_d;
    end
  end

  assign pix_out.valid   = out_vld_q;
  assign pix_out.out_r   = res_q[0];
  assign pix_out.out_g   = res_q[1];
  assign pix_out.out_b   = res_q[2];
  assign pix_out.out_a   = res_q[3];
  assign pix_out.changed = chg_q;

`ifndef NO_ASSERTIONS
  // A pixel outside the disc cannot have a distance below the radius.
  a_root_past_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld && !sq_side.fill |-> sq_root >= rf)
    else $error("root below radius for a pixel outside the disc");

  // A nonzero foreground alpha gives a nonzero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blv_q[3] && bl_q[3].kind == KIND_BLEND && bl_q[3].fa != '0 |-> bl_q[3].s != '0)
    else $error("zero divisor in over operator");

  // Composited alpha never drops below the foreground alpha.
  a_alpha_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && blv_q[BL_LAST] && fin.kind == KIND_BLEND && fin.fa != '0
    |=> pix_out.out_a >= $past(fin.fa))
    else $error("blended alpha below foreground alpha");
`endif

endmodule

`default_nettype wire

// ===== sim/adcomp_checker.sv =====
// Checker for the antialiased disc pixel compositor: watches both pixel channels and
// the register port, predicts every output word and compares it field by field.
// Depends on adcomp_pkg and adcomp_if.
`default_nettype none

module adcomp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  adcomp_in_if                          pin,
  adcomp_out_if                         pout,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [adcomp_pkg::ADDR_W-1:0] paddr,
  input  logic [adcomp_pkg::DATA_W-1:0] pwdata,
  output int                            fail_cnt_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import adcomp_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] a;
    logic            changed;
  } shade_t;

  cfg_t   regs;
  shade_t shade_q[$];

  // Floor of sqrt(n) * 2^extra, one root bit per step.
  function automatic longint unsigned dist_root(input longint unsigned n, input int extra);
    longint unsigned root, rem, trial;
    root = 0;
    rem  = 0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((n >> (2 * i)) & 3);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    for (int k = 0; k < extra; k++) begin
      rem   = rem << 2;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Porter-Duff over with exact integer division; index 0..3 is r, g, b, a.
  function automatic void over_blend(input longint unsigned bg[4], input longint unsigned fg[4],
                                     output longint unsigned res[4]);
    longint unsigned wf, wb, s;
    if (fg[3] == 0) begin
      res = bg;
      return;
    end
    wf = fg[3] * 255;
    wb = bg[3] * (255 - fg[3]);
    s  = wf + wb;
    for (int c = 0; c < 3; c++) res[c] = (fg[c] * wf + bg[c] * wb) / s;
    res[3] = s / 255;
  endfunction

  function automatic longint unsigned sq_diff(input longint unsigned p, input longint unsigned q);
    longint unsigned d;
    d = (p >= q) ? p - q : q - p;
    return d * d;
  endfunction

  function automatic shade_t shade_pixel(input logic op, input logic [COORD_BITS-1:0] px,
                                         input logic [COORD_BITS-1:0] py, input rgba_t pix);
    longint unsigned inp[4], res[4], fg[4], white[4];
    longint unsigned rq, dd, d, rf, e, cov, band;
    logic chg;
    shade_t s;
    for (int c = 0; c < 4; c++) inp[c] = pix[c];
    res = inp;
    chg = 1'b0;
    if (op) begin
      for (int c = 0; c < 4; c++) white[c] = 255;
      over_blend(white, inp, res);
      chg = 1'b1;
    end else begin
      rq = longint'(regs.radius) * regs.scale;
      dd = sq_diff(longint'(regs.center_x) * regs.scale, longint'(px) << 4)
         + sq_diff(longint'(regs.center_y) * regs.scale, longint'(py) << 4);
      if (dd <= rq * rq) begin
        res[0] = regs.color_r;
        res[1] = regs.color_g;
        res[2] = regs.color_b;
        res[3] = regs.color_a;
        chg = 1'b1;
      end else begin
        d    = dist_root(dd, FRAC_BITS - 4);
        rf   = rq << (FRAC_BITS - 4);
        band = longint'(AA_WIDTH) << FRAC_BITS;
        e    = (d > rf) ? d - rf : 0;
        if (e < band) begin
          cov = (band - e) / AA_WIDTH;
          if (cov > 0) begin
            fg[0] = regs.color_r;
            fg[1] = regs.color_g;
            fg[2] = regs.color_b;
            fg[3] = (longint'(regs.color_a) * cov) >> FRAC_BITS;
            over_blend(inp, fg, res);
            chg = 1'b1;
          end
        end
      end
    end
    s.r = res[0][7:0];
    s.g = res[1][7:0];
    s.b = res[2][7:0];
    s.a = res[3][7:0];
    s.changed = chg;
    return s;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs <= '{center_x: '0, center_y: '0, radius: '0, scale: 7'd1,
                color_r: 8'd255, color_g: '0, color_b: '0, color_a: 8'd255};
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[ADDR_W-1:2])
        REG_CENTER_X: regs.center_x <= pwdata[CTR_W-1:0];
        REG_CENTER_Y: regs.center_y <= pwdata[CTR_W-1:0];
        REG_RADIUS:   regs.radius   <= pwdata[RAD_W-1:0];
        REG_SCALE:    regs.scale    <= pwdata[SCL_W-1:0];
        REG_COLOR_R:  regs.color_r  <= pwdata[CH_W-1:0];
        REG_COLOR_G:  regs.color_g  <= pwdata[CH_W-1:0];
        REG_COLOR_B:  regs.color_b  <= pwdata[CH_W-1:0];
        REG_COLOR_A:  regs.color_a  <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    shade_t want, got;
    if (rst_ni) begin
      if (pin.valid && pin.ready)
        shade_q.push_back(shade_pixel(pin.operation, pin.pixel_x, pin.pixel_y,
                                      {pin.pixel_a, pin.pixel_b, pin.pixel_g, pin.pixel_r}));
      if (pout.valid && pout.ready) begin
        got = '{pout.out_r, pout.out_g, pout.out_b, pout.out_a, pout.changed};
        if (shade_q.size() == 0) begin
          $display("%0t: output word with nothing expected: %p", $time, got);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          want = shade_q.pop_front();
          if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
              got.a !== want.a || got.changed !== want.changed) begin
            $display("%0t: expected rgba %0d %0d %0d %0d changed %0b, got %0d %0d %0d %0d %0b",
                     $time, want.r, want.g, want.b, want.a, want.changed,
                     got.r, got.g, got.b, got.a, got.changed);
            fail_cnt_o = fail_cnt_o + 1;
          end
        end
      end
    end else begin
      fail_cnt_o = 0;
    end
    pending_o = shade_q.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Top of the compositor testbench: clock, reset, register writes, pixel stimulus,
// output stalls, watchdog and verdict.
// Depends on adcomp_pkg, adcomp_if, the compositor RTL and adcomp_checker.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import adcomp_pkg::*;

  localparam int WATCH_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic              clk_i;
  logic              rst_ni;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int                fail_cnt, pending;
  bit                quiet;
  int                out_stall;
  int                idle_cycles;
  int                cx, cy, rad, scl;

  adcomp_in_if  pin ();
  adcomp_out_if pout ();

  antialiased_disc_pixel_compositor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_in (pin),
    .pix_out(pout),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  adcomp_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pin       (pin),
    .pout      (pout),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: a random stall before each word, none during quiet phases.
  always @(posedge clk_i) begin
    if (pout.valid && pout.ready) begin
      out_stall = quiet ? 0 : $urandom_range(0, 13);
    end
    if (out_stall > 0) begin
      pout.ready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      pout.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pin.valid && pin.ready) || (pout.valid && pout.ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_e idx, input int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_X: cx  = value & 16'hffff;
      REG_CENTER_Y: cy  = value & 16'hffff;
      REG_RADIUS:   rad = value & 12'hfff;
      REG_SCALE:    scl = value & 7'h7f;
      default: ;
    endcase
  endtask

  task automatic set_disc(input int x, input int y, input int r, input int s,
                          input int cr, input int cg, input int cb, input int ca);
    reg_write(REG_CENTER_X, x);
    reg_write(REG_CENTER_Y, y);
    reg_write(REG_RADIUS, r);
    reg_write(REG_SCALE, s);
    reg_write(REG_COLOR_R, cr);
    reg_write(REG_COLOR_G, cg);
    reg_write(REG_COLOR_B, cb);
    reg_write(REG_COLOR_A, ca);
  endtask

  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_pixel(input logic op, input int x, input int y, input rgba_t pix);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pin.valid     <= 1'b1;
    pin.operation <= op;
    pin.pixel_x   <= COORD_BITS'(x);
    pin.pixel_y   <= COORD_BITS'(y);
    pin.pixel_r   <= pix[0];
    pin.pixel_g   <= pix[1];
    pin.pixel_b   <= pix[2];
    pin.pixel_a   <= pix[3];
    @(negedge clk_i);
    while (!pin.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Lower valid, let every expected word come out, then let the pipeline settle.
  task automatic drain();
    pin.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  function automatic rgba_t rand_rgba();
    return rgba_t'($urandom());
  endfunction

  // Mostly pixels in a box around the disc, the rest anywhere on the frame.
  task automatic random_pixel();
    int span, px, py;
    rgba_t pix;
    pix = rand_rgba();
    if ($urandom_range(0, 9) == 0) pix[3] = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
    if ($urandom_range(0, 9) < 7) begin
      span = (rad * scl) / 16 + 4;
      if (span > 4095) span = 4095;
      px = clamp_coord((cx * scl) / 16 + $urandom_range(0, 2 * span) - span);
      py = clamp_coord((cy * scl) / 16 + $urandom_range(0, 2 * span) - span);
    end else begin
      px = $urandom_range(0, 4095);
      py = $urandom_range(0, 4095);
    end
    send_pixel($urandom_range(0, 4) == 0, px, py, pix);
  endtask

  initial begin
    int s;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    pin.valid   = 1'b0;
    pin.operation = 1'b0;
    pin.pixel_x = '0;
    pin.pixel_y = '0;
    pin.pixel_r = '0;
    pin.pixel_g = '0;
    pin.pixel_b = '0;
    pin.pixel_a = '0;
    quiet       = 1'b0;
    cx = 0; cy = 0; rad = 0; scl = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: zero radius at the origin fills only the corner pixel.
    send_pixel(1'b0, 0, 0, 32'h12345678);
    send_pixel(1'b0, 1, 0, 32'h80402010);
    send_pixel(1'b0, 4095, 4095, 32'hffffffff);
    send_pixel(1'b1, 4095, 0, 32'h00ffffff);
    send_pixel(1'b1, 0, 4095, 32'hff000000);
    send_pixel(1'b1, 7, 9, 32'h80c08040);
    drain();

    // Disc at pixel (100,100), radius 10: fill, anti-alias band and pass.
    set_disc(100 * 16, 100 * 16, 160, 1, 20, 200, 90, 180);
    for (int i = 9; i <= 14; i++) send_pixel(1'b0, 100 + i, 100, 32'h40ff8020);
    send_pixel(1'b0, 101, 111, 32'h00000000);
    send_pixel(1'b0, 108, 108, 32'hffffffff);
    drain();

    // Transparent disc colour: blended pixels come out unchanged but flagged.
    reg_write(REG_COLOR_A, 0);
    send_pixel(1'b0, 111, 100, 32'h7f3c2a19);
    send_pixel(1'b0, 100, 100, 32'h7f3c2a19);
    drain();

    // Extreme centre and scale values.
    set_disc(65535, 65535, 4095, 127, 255, 255, 255, 255);
    send_pixel(1'b0, 4095, 4095, 32'h01020304);
    send_pixel(1'b0, 0, 0, 32'h01020304);
    drain();
    reg_write(REG_SCALE, 0);
    send_pixel(1'b0, 0, 0, 32'haabbccdd);
    send_pixel(1'b0, 3, 0, 32'haabbccdd);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph % 4 == 3);
      case (ph)
        0: s = 1;
        1: s = 64;
        2: s = 0;
        3: s = 127;
        default: s = $urandom_range(1, 64);
      endcase
      reg_write(REG_SCALE, s);
      reg_write(REG_CENTER_X, $urandom_range(0, (s == 0) ? 65535 : 65535 / s));
      reg_write(REG_CENTER_Y, $urandom_range(0, (s == 0) ? 65535 : 65535 / s));
      reg_write(REG_RADIUS, (ph == 5) ? 4095 : (ph == 6) ? 0 :
                $urandom_range(0, (s == 0) ? 4095 : 640 / s));
      reg_write(REG_COLOR_R, $urandom_range(0, 255));
      reg_write(REG_COLOR_G, $urandom_range(0, 255));
      reg_write(REG_COLOR_B, $urandom_range(0, 255));
      reg_write(REG_COLOR_A, (ph == 7) ? 0 : (ph == 8) ? 255 : $urandom_range(0, 255));
      for (int i = 0; i < 100; i++) random_pixel();
      drain();
    end

    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
